// ===== hw/rtl/mcst_pkg.sv =====
package mcst_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int NUM_LEVELS_DEF = 4;
    localparam int COUNT_BITS_DEF = 16;

    localparam int ID_W    = 4;
    localparam int VAL_W   = 16;
    localparam int REP_W   = 8;
    localparam int PRIO_W  = 8;
    localparam int LVL_W   = 2;
    localparam int LIM_W   = 5;
    localparam int PRE_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W   = 16;

    localparam logic [REP_W-1:0] REP_PERIODIC = 8'hFF;
    localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_VALUE = 1'd1;

    localparam logic [3:0] FN_ALLOC    = 4'd0;
    localparam logic [3:0] FN_START    = 4'd1;
    localparam logic [3:0] FN_PAUSE    = 4'd2;
    localparam logic [3:0] FN_CONTINUE = 4'd3;
    localparam logic [3:0] FN_RELOAD   = 4'd4;
    localparam logic [3:0] FN_PRIORITY = 4'd5;
    localparam logic [3:0] FN_SETREP   = 4'd6;
    localparam logic [3:0] FN_ADDREP   = 4'd7;
    localparam logic [3:0] FN_PRESCON  = 4'd8;
    localparam logic [3:0] FN_PRESCOFF = 4'd9;
    localparam logic [3:0] FN_RESIZE   = 4'd10;
    localparam logic [3:0] FN_OFF      = 4'd11;
    localparam logic [3:0] FN_STATUS   = 4'd12;
    localparam logic [3:0] FN_TICK     = 4'd13;
    localparam logic [3:0] FN_COLLECT  = 4'd14;

    typedef struct packed {
        logic [3:0]        func;
        logic [ID_W-1:0]   timer_id;
        logic [VAL_W-1:0]  value;
        logic [REP_W-1:0]  repeats;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]  id_out;
        logic             found;
        logic             enabled_out;
        logic             pending_out;
        logic             prescaled_out;
        logic [LVL_W-1:0] level_out;
        logic [REP_W-1:0] repeats_out;
        logic [VAL_W-1:0] reload_out;
        logic [VAL_W-1:0] count_out;
        logic             last;
    } result_t;

    // one timer entry as the shared update unit sees it
    typedef struct packed {
        logic             run;
        logic             pend;
        logic             pres;
        logic [LVL_W-1:0] level;
        logic [REP_W-1:0] rep;
        logic [31:0]      reload;
        logic [31:0]      count;
    } entry_t;

endpackage

// ===== hw/rtl/mcst_entry_unit.sv =====
module mcst_entry_unit
    import mcst_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic [3:0]            func,
    input  logic [VAL_W-1:0]      value,
    input  logic [REP_W-1:0]      repeats,
    input  logic [PRIO_W-1:0]     priority_req,
    input  logic                  pre_zero,
    input  entry_t                cur,
    output entry_t                nxt
);

    logic [LVL_W-1:0]      clamp_lvl;
    logic [REP_W:0]        rep_sum;
    logic [COUNT_BITS-1:0] val_m;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [REP_W-1:0]      rep_dec;

    always_comb
    begin
        if (priority_req < PRIO_W'(NUM_LEVELS))
            clamp_lvl = LVL_W'(priority_req);
        else if (priority_req == PRIO_CRITICAL)
            clamp_lvl = '0;
        else
            clamp_lvl = LVL_W'(NUM_LEVELS - 1);
    end

    assign rep_sum = {1'b0, repeats} + {1'b0, cur.rep};
    assign val_m   = COUNT_BITS'(value);
    assign cnt_dec = cur.count[COUNT_BITS-1:0] - 1'b1;
    assign rep_dec = (cur.rep != '0) ? cur.rep - 1'b1 : cur.rep;

    always_comb
    begin
        nxt = cur;
        unique case (func)
            FN_ALLOC:
            begin
                nxt.level  = clamp_lvl;
                nxt.rep    = REP_PERIODIC;
                nxt.reload = 32'(val_m);
                nxt.count  = 32'(val_m);
                nxt.run    = 1'b0;
                nxt.pend   = 1'b0;
                nxt.pres   = 1'b0;
            end
            FN_START:
            begin
                nxt.count = cur.reload;
                if (repeats != '0)
                    nxt.rep = repeats;
                nxt.run = 1'b1;
            end
            FN_PAUSE:    nxt.run = 1'b0;
            FN_CONTINUE: nxt.run = 1'b1;
            FN_RELOAD:   nxt.count = cur.reload;
            FN_PRIORITY: nxt.level = clamp_lvl;
            FN_SETREP:
            begin
                if (repeats != '0)
                    nxt.rep = repeats;
            end
            FN_ADDREP:
            begin
                if (repeats != '0)
                    nxt.rep = rep_sum[REP_W] ? REP_PERIODIC : rep_sum[REP_W-1:0];
            end
            FN_PRESCON:  nxt.pres = 1'b1;
            FN_PRESCOFF: nxt.pres = 1'b0;
            FN_RESIZE:
            begin
                nxt.reload = 32'(val_m);
                nxt.count  = 32'(val_m);
            end
            FN_OFF:
            begin
                nxt.run   = 1'b0;
                nxt.count = cur.reload;
            end
            FN_TICK:
            begin
                if (cur.run)
                begin
                    if (cur.count[COUNT_BITS-1:0] == '0)
                    begin
                        nxt.pend  = 1'b1;
                        nxt.count = cur.reload;
                        if (cur.rep != REP_PERIODIC)
                        begin
                            nxt.rep = rep_dec;
                            if (rep_dec == '0)
                                nxt.run = 1'b0;
                        end
                    end
                    else if (!cur.pres || pre_zero)
                        nxt.count = 32'(cnt_dec);
                end
            end
            FN_COLLECT:
            begin
                if (cur.pend && (32'(cur.level) == 32'(priority_req)))
                    nxt.pend = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/multi_channel_soft_timer_core.sv =====
// Single-entry commands: the command is captured in ST_IDLE and the result registered in ST_ONE.
// Tick and collect walk the allocated timers, one entry per cycle, in
// ST_WALK, then finish in ST_DONE; busy stays high throughout.
// Throughput: one command at a time; the next start is taken once busy falls.
// Results appear on result for one cycle under result_valid; the receiver cannot stall.
// Reset: asynchronous active-low rst_n clears all timers, limit 16, prescale 10.
module multi_channel_soft_timer_core
    import mcst_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // timer storage, one flop row per timer
    logic [COUNT_BITS-1:0] reload_reg [NUM_TIMERS];
    logic [COUNT_BITS-1:0] count_reg  [NUM_TIMERS];
    logic [REP_W-1:0]      rep_reg    [NUM_TIMERS];
    logic [LVL_W-1:0]      lvl_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg, pend_reg, pres_reg;
    logic [CW-1:0]         alloc_reg;
    logic [PRE_W-1:0]      pre_cnt_reg;
    logic [LIM_W-1:0]      limit_reg;
    logic [PRE_W-1:0]      pre_val_reg;

    logic [1:0]   state_reg, state_next;
    cmd_t         cmd_reg;
    logic [CW-1:0] idx_reg;          // walk pointer
    logic [4:0]   nout_reg;          // results given in this collect
    logic         hold_valid_reg;    // a collect hit waits for its successor
    result_t      hold_reg;
    logic         rv_reg;
    result_t      res_reg;

    logic [IW-1:0] sel;
    entry_t        cur, nxt;
    logic          pre_zero;
    logic [PRE_W-1:0] pre_dec;
    logic          id_ok;
    logic [CW-1:0] lim_eff;
    result_t       stat;
    result_t       stat_last;
    result_t       hold_last;
    result_t       none_res;
    logic          walk_hit;

    assign busy = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign result = res_reg;

    assign pre_dec  = pre_cnt_reg - 1'b1;
    // the walk runs after the counter has already advanced for this tick
    assign pre_zero = (pre_cnt_reg == '0);
    assign id_ok    = (32'(cmd_reg.timer_id) < NUM_TIMERS);
    assign lim_eff  = (32'(limit_reg) < NUM_TIMERS) ? CW'(limit_reg) : CW'(NUM_TIMERS);

    // pick the row that the shared unit works on
    always_comb
    begin
        if (state_reg == ST_WALK)
            sel = IW'(idx_reg);
        else if (cmd_reg.func == FN_ALLOC)
            sel = IW'(alloc_reg);
        else
            sel = IW'(cmd_reg.timer_id);
    end

    always_comb
    begin
        cur.run    = run_reg[sel];
        cur.pend   = pend_reg[sel];
        cur.pres   = pres_reg[sel];
        cur.level  = lvl_reg[sel];
        cur.rep    = rep_reg[sel];
        cur.reload = 32'(reload_reg[sel]);
        cur.count  = 32'(count_reg[sel]);
    end

    mcst_entry_unit #(
        .NUM_LEVELS (NUM_LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .func         (cmd_reg.func),
        .value        (cmd_reg.value),
        .repeats      (cmd_reg.repeats),
        .priority_req (cmd_reg.priority_req),
        .pre_zero     (pre_zero),
        .cur          (cur),
        .nxt          (nxt)
    );

    always_comb
    begin
        stat.id_out        = ID_W'(sel);
        stat.found         = 1'b1;
        stat.enabled_out   = cur.run;
        stat.pending_out   = cur.pend;
        stat.prescaled_out = cur.pres;
        stat.level_out     = cur.level;
        stat.repeats_out   = cur.rep;
        stat.reload_out    = VAL_W'(cur.reload);
        stat.count_out     = VAL_W'(cur.count);
        stat.last          = 1'b0;
    end

    // final-result variants: status or held hit marked last, and the empty answer
    always_comb
    begin
        stat_last      = stat;
        stat_last.last = 1'b1;
        hold_last      = hold_reg;
        hold_last.last = 1'b1;
        none_res       = '0;
        none_res.last  = 1'b1;
    end

    assign walk_hit = cur.pend && (32'(cur.level) == 32'(cmd_reg.priority_req))
                      && (nout_reg < 5'd16);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_ONE;
            ST_ONE:
            begin
                if (cmd_reg.func == FN_TICK || cmd_reg.func == FN_COLLECT)
                    state_next = (alloc_reg == '0) ? ST_DONE : ST_WALK;
                else
                    state_next = ST_IDLE;
            end
            ST_WALK: if (idx_reg + 1'b1 >= alloc_reg) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_reg        <= '0;
            pend_reg       <= '0;
            pres_reg       <= '0;
            alloc_reg      <= '0;
            pre_cnt_reg    <= PRE_W'(10);
            limit_reg      <= LIM_W'(16);
            pre_val_reg    <= PRE_W'(10);
            rv_reg         <= 1'b0;
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
            nout_reg       <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                reload_reg[i] <= '0;
                count_reg[i]  <= '0;
                rep_reg[i]    <= '0;
                lvl_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIMER_LIMIT:    limit_reg   <= LIM_W'(cfg_data);
                    CFG_PRESCALE_VALUE: pre_val_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                        cmd_reg <= cmd;
                    idx_reg        <= '0;
                    nout_reg       <= '0;
                    hold_valid_reg <= 1'b0;
                end
                ST_ONE:
                begin
                    if (cmd_reg.func == FN_ALLOC)
                    begin
                        rv_reg <= 1'b1;
                        if (alloc_reg < lim_eff)
                        begin
                            run_reg[sel]    <= nxt.run;
                            pend_reg[sel]   <= nxt.pend;
                            pres_reg[sel]   <= nxt.pres;
                            lvl_reg[sel]    <= nxt.level;
                            rep_reg[sel]    <= nxt.rep;
                            reload_reg[sel] <= COUNT_BITS'(nxt.reload);
                            count_reg[sel]  <= COUNT_BITS'(nxt.count);
                            alloc_reg       <= alloc_reg + 1'b1;
                            res_reg <= '{id_out: ID_W'(sel), found: 1'b1,
                                         enabled_out: nxt.run, pending_out: nxt.pend,
                                         prescaled_out: nxt.pres, level_out: nxt.level,
                                         repeats_out: nxt.rep,
                                         reload_out: VAL_W'(nxt.reload),
                                         count_out: VAL_W'(nxt.count), last: 1'b1};
                        end
                        else
                        begin
                            res_reg <= none_res;
                        end
                    end
                    else if (cmd_reg.func == FN_TICK)
                        pre_cnt_reg <= pre_dec;
                    else if (cmd_reg.func == FN_COLLECT)
                        ;
                    else if (cmd_reg.func == FN_STATUS)
                    begin
                        rv_reg <= 1'b1;
                        if (id_ok)
                        begin
                            res_reg <= stat_last;
                        end
                        else
                        begin
                            res_reg <= none_res;
                        end
                    end
                    else if (id_ok)
                    begin
                        // unused codes leave the entry as it is
                        run_reg[sel]    <= nxt.run;
                        pres_reg[sel]   <= nxt.pres;
                        lvl_reg[sel]    <= nxt.level;
                        rep_reg[sel]    <= nxt.rep;
                        reload_reg[sel] <= COUNT_BITS'(nxt.reload);
                        count_reg[sel]  <= COUNT_BITS'(nxt.count);
                    end
                end
                ST_WALK:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (cmd_reg.func == FN_TICK)
                    begin
                        // prescale counter already advanced; pre_zero looks at it directly
                        run_reg[sel]   <= nxt.run;
                        pend_reg[sel]  <= nxt.pend;
                        rep_reg[sel]   <= nxt.rep;
                        count_reg[sel] <= COUNT_BITS'(nxt.count);
                    end
                    else if (walk_hit)
                    begin
                        pend_reg[sel] <= 1'b0;
                        nout_reg      <= nout_reg + 1'b1;
                        // emit the held hit; keep this one until the next is known
                        if (hold_valid_reg)
                        begin
                            rv_reg  <= 1'b1;
                            res_reg <= hold_reg;
                        end
                        hold_reg       <= stat;
                        hold_valid_reg <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (cmd_reg.func == FN_TICK)
                    begin
                        if (pre_cnt_reg == '0)
                            pre_cnt_reg <= pre_val_reg;
                    end
                    else
                    begin
                        rv_reg <= 1'b1;
                        if (hold_valid_reg)
                        begin
                            res_reg <= hold_last;
                        end
                        else
                        begin
                            res_reg <= none_res;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== dv/multi_channel_soft_timer_core_tb.sv =====
`timescale 1ns / 100ps

module multi_channel_soft_timer_core_tb;
    import mcst_pkg::*;

    localparam int TIMERS      = 16;
    localparam int LEVELS      = 4;
    localparam int SETTLE      = 24;    // walk of 16 entries plus pipeline
    localparam int IDLE_LIMIT  = 5000;

    localparam logic [3:0] FN_UNUSED = 4'd15;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    multi_channel_soft_timer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the timer bank, advanced at each accepted transaction.
    logic [15:0]  shadow_reload [TIMERS];
    logic [15:0]  shadow_count  [TIMERS];
    logic [7:0]   shadow_rep    [TIMERS];
    logic [1:0]   shadow_level  [TIMERS];
    logic [TIMERS-1:0] shadow_run;
    logic [TIMERS-1:0] shadow_pend;
    logic [TIMERS-1:0] shadow_pres;
    int unsigned  shadow_alloc;
    logic [15:0]  shadow_prescnt;
    logic [4:0]   shadow_limit;
    logic [15:0]  shadow_psval;

    result_t      expected_results[$];
    int unsigned  mismatch_count;
    int unsigned  idle_cycles;
    int unsigned  sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [1:0] level_of(logic [7:0] p);
        if (p < LEVELS) return p[1:0];
        if (p == PRIO_CRITICAL) return 2'd0;
        return 2'(LEVELS - 1);
    endfunction

    function automatic result_t timer_status(int i);
        result_t r;
        r = '0;
        r.id_out        = i[3:0];
        r.found         = 1'b1;
        r.enabled_out   = shadow_run[i];
        r.pending_out   = shadow_pend[i];
        r.prescaled_out = shadow_pres[i];
        r.level_out     = shadow_level[i];
        r.repeats_out   = shadow_rep[i];
        r.reload_out    = shadow_reload[i];
        r.count_out     = shadow_count[i];
        return r;
    endfunction

    function automatic result_t no_timer();
        result_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic bank_reset();
        for (int i = 0; i < TIMERS; i++)
        begin
            shadow_reload[i] = '0;
            shadow_count[i]  = '0;
            shadow_rep[i]    = '0;
            shadow_level[i]  = '0;
        end
        shadow_run     = '0;
        shadow_pend    = '0;
        shadow_pres    = '0;
        shadow_alloc   = 0;
        shadow_limit   = 5'd16;
        shadow_psval   = 16'd10;
        shadow_prescnt = 16'd10;
    endtask

    // Advance the shadow bank by one command and queue the results it yields.
    task automatic predict_timer_cmd(cmd_t c);
        int unsigned lim;
        int          n;
        int          id;
        int unsigned sum;
        result_t     r;
        id = c.timer_id;
        case (c.func)
            FN_ALLOC:
            begin
                lim = (shadow_limit < TIMERS) ? shadow_limit : TIMERS;
                if (shadow_alloc < lim)
                begin
                    shadow_level[shadow_alloc]  = level_of(c.priority_req);
                    shadow_rep[shadow_alloc]    = REP_PERIODIC;
                    shadow_reload[shadow_alloc] = c.value;
                    shadow_count[shadow_alloc]  = c.value;
                    shadow_run[shadow_alloc]    = 1'b0;
                    shadow_pend[shadow_alloc]   = 1'b0;
                    shadow_pres[shadow_alloc]   = 1'b0;
                    r = timer_status(shadow_alloc);
                    r.last = 1'b1;
                    shadow_alloc++;
                    expected_results.push_back(r);
                end
                else
                begin
                    expected_results.push_back(no_timer());
                end
            end
            FN_TICK:
            begin
                shadow_prescnt = shadow_prescnt - 16'd1;
                for (int i = 0; i < shadow_alloc; i++)
                begin
                    if (!shadow_run[i]) continue;
                    if (shadow_count[i] == 0)
                    begin
                        shadow_pend[i]  = 1'b1;
                        shadow_count[i] = shadow_reload[i];
                        if (shadow_rep[i] != REP_PERIODIC)
                        begin
                            if (shadow_rep[i] != 0) shadow_rep[i]--;
                            if (shadow_rep[i] == 0) shadow_run[i] = 1'b0;
                        end
                    end
                    else if (shadow_pres[i])
                    begin
                        if (shadow_prescnt == 0) shadow_count[i]--;
                    end
                    else
                    begin
                        shadow_count[i]--;
                    end
                end
                if (shadow_prescnt == 0) shadow_prescnt = shadow_psval;
            end
            FN_COLLECT:
            begin
                n = 0;
                for (int i = 0; i < shadow_alloc; i++)
                begin
                    if (shadow_pend[i] && shadow_level[i] == c.priority_req)
                    begin
                        expected_results.push_back(timer_status(i));
                        shadow_pend[i] = 1'b0;
                        n++;
                    end
                end
                if (n == 0) expected_results.push_back(no_timer());
                else expected_results[$].last = 1'b1;
            end
            FN_START:
            begin
                shadow_count[id] = shadow_reload[id];
                if (c.repeats != 0) shadow_rep[id] = c.repeats;
                shadow_run[id] = 1'b1;
            end
            FN_PAUSE:    shadow_run[id] = 1'b0;
            FN_CONTINUE: shadow_run[id] = 1'b1;
            FN_RELOAD:   shadow_count[id] = shadow_reload[id];
            FN_PRIORITY: shadow_level[id] = level_of(c.priority_req);
            FN_SETREP:   if (c.repeats != 0) shadow_rep[id] = c.repeats;
            FN_ADDREP:
            begin
                if (c.repeats != 0)
                begin
                    sum = c.repeats + shadow_rep[id];
                    shadow_rep[id] = (sum > 255) ? 8'hFF : sum[7:0];
                end
            end
            FN_PRESCON:  shadow_pres[id] = 1'b1;
            FN_PRESCOFF: shadow_pres[id] = 1'b0;
            FN_RESIZE:
            begin
                shadow_reload[id] = c.value;
                shadow_count[id]  = c.value;
            end
            FN_OFF:
            begin
                shadow_run[id]   = 1'b0;
                shadow_count[id] = shadow_reload[id];
            end
            FN_STATUS:
            begin
                r = timer_status(id);
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare every strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", result));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.id_out !== want.id_out)
                    report_mismatch($sformatf("id_out %0d want %0d", result.id_out, want.id_out));
                if (result.found !== want.found)
                    report_mismatch($sformatf("found %b want %b", result.found, want.found));
                if (result.enabled_out !== want.enabled_out)
                    report_mismatch($sformatf("enabled_out %b want %b id %0d",
                                              result.enabled_out, want.enabled_out, want.id_out));
                if (result.pending_out !== want.pending_out)
                    report_mismatch($sformatf("pending_out %b want %b id %0d",
                                              result.pending_out, want.pending_out, want.id_out));
                if (result.prescaled_out !== want.prescaled_out)
                    report_mismatch($sformatf("prescaled_out %b want %b id %0d",
                                              result.prescaled_out, want.prescaled_out,
                                              want.id_out));
                if (result.level_out !== want.level_out)
                    report_mismatch($sformatf("level_out %0d want %0d id %0d",
                                              result.level_out, want.level_out, want.id_out));
                if (result.repeats_out !== want.repeats_out)
                    report_mismatch($sformatf("repeats_out %0d want %0d id %0d",
                                              result.repeats_out, want.repeats_out, want.id_out));
                if (result.reload_out !== want.reload_out)
                    report_mismatch($sformatf("reload_out %0d want %0d id %0d",
                                              result.reload_out, want.reload_out, want.id_out));
                if (result.count_out !== want.count_out)
                    report_mismatch($sformatf("count_out %0d want %0d id %0d",
                                              result.count_out, want.count_out, want.id_out));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %b want %b id %0d",
                                              result.last, want.last, want.id_out));
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL multi_channel_soft_timer_core");
            $finish;
        end
    end

    // Present one command and hold it until the block takes it; start stays high
    // so that a back-to-back command can follow at the same edge.
    task automatic send_cmd(cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        predict_timer_cmd(c);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic issue(logic [3:0] f, int id = 0, int val = 0, int rep = 0, int prio = 0);
        cmd_t c;
        c.func         = f;
        c.timer_id     = id[3:0];
        c.value        = val[15:0];
        c.repeats      = rep[7:0];
        c.priority_req = prio[7:0];
        send_cmd(c);
    endtask

    // Drop start, drain outstanding results and let any walk finish.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TIMER_LIMIT) shadow_limit = data[4:0];
        else shadow_psval = data[15:0];
    endtask

    task automatic test_alloc_and_clamp();
        issue(FN_STATUS, 5);                 // never allocated, reset contents
        issue(FN_ALLOC, 9, 0, 0, 0);
        issue(FN_ALLOC, 0, 16'hFFFF, 0, 3);
        issue(FN_ALLOC, 0, 2, 0, 4);          // clamps to top level
        issue(FN_ALLOC, 0, 1, 0, 255);        // critical maps to level 0
        issue(FN_ALLOC, 0, 3, 0, 200);
    endtask

    task automatic test_expiry_and_collect();
        issue(FN_START, 0, 0, 2);             // zero-length timer, two repeats
        issue(FN_START, 2, 0, 0);             // repeats zero keeps periodic
        issue(FN_START, 3, 0, 1);
        repeat (4) issue(FN_TICK);
        issue(FN_COLLECT, 0, 0, 0, 0);
        issue(FN_COLLECT, 0, 0, 0, 3);
        issue(FN_COLLECT, 0, 0, 0, 2);        // nothing pending there
        issue(FN_STATUS, 0);
    endtask

    task automatic test_single_ops();
        issue(FN_PAUSE, 2);
        issue(FN_CONTINUE, 2);
        issue(FN_RESIZE, 1, 16'hA5A5);
        issue(FN_RELOAD, 1);
        issue(FN_PRIORITY, 1, 0, 0, 255);
        issue(FN_SETREP, 1, 0, 250);
        issue(FN_ADDREP, 1, 0, 10);           // saturates
        issue(FN_ADDREP, 1, 0, 0);
        issue(FN_SETREP, 1, 0, 0);
        issue(FN_PRESCON, 4);
        issue(FN_START, 4, 0, 5);
        repeat (3) issue(FN_TICK);
        issue(FN_PRESCOFF, 4);
        issue(FN_OFF, 2);
        issue(FN_UNUSED, 3);                  // unused code does nothing
        issue(FN_STATUS, 1);
        issue(FN_STATUS, 4);
    endtask

    task automatic test_limit_lowered();
        drain();
        write_reg(CFG_TIMER_LIMIT, 2);
        issue(FN_ALLOC, 0, 7);                // below existing count: fails
        issue(FN_STATUS, 4);
        drain();
        write_reg(CFG_TIMER_LIMIT, 0);
        issue(FN_ALLOC);
        drain();
        write_reg(CFG_TIMER_LIMIT, 31);       // clamps to bank size
    endtask

    function automatic int pick_len();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(0, 4);
    endfunction

    task automatic random_traffic(int items);
        int f;
        int w;
        for (int k = 0; k < items; k++)
        begin
            w = $urandom_range(99);
            if (w < 35)      f = FN_TICK;
            else if (w < 50) f = FN_COLLECT;
            else if (w < 56) f = FN_ALLOC;
            else if (w < 64) f = FN_START;
            else if (w < 70) f = FN_STATUS;
            else             f = $urandom_range(0, 15);
            issue(f[3:0], $urandom_range(0, 15), pick_len(),
                  ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3),
                  (f == FN_COLLECT) ? (($urandom_range(9) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3))
                                    : $urandom_range(0, 255));
        end
    endtask

    task automatic test_random_phases();
        int unsigned pct_list[3] = '{0, 85, 33};
        int          ps_list[4]  = '{1, 0, 65535, 3};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(CFG_PRESCALE_VALUE, ps_list[p]);
            write_reg(CFG_TIMER_LIMIT, (p == 3) ? 16 : $urandom_range(0, 16));
            sender_idle_pct = pct_list[p % 3];
            random_traffic(62);
        end
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        bank_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_and_clamp();
        test_expiry_and_collect();
        sender_idle_pct = 85;
        test_single_ops();
        test_limit_lowered();
        test_random_phases();

        if (mismatch_count == 0)
            $display("PASS multi_channel_soft_timer_core");
        else
            $display("FAIL multi_channel_soft_timer_core");
        $finish;
    end

endmodule
